FILE: rtl/core/lipg_pkg.sv
package lipg_pkg;

    localparam int unsigned MAX_POINTS_DEF = 64;
    localparam int unsigned CNT_W          = 7;
    localparam int unsigned NUM_W          = 67;
    localparam int unsigned DEN_W          = 33;
    localparam int unsigned STEP_ITERS     = 40;
    localparam int unsigned SLOPE_ITERS    = 67;
    localparam int unsigned MUL_STEPS      = 33;

    localparam logic signed [41:0] S32_MAX = 42'sd2147483647;
    localparam logic signed [41:0] S32_MIN = -42'sd2147483648;
    localparam logic [66:0]        Q_CLAMP = 67'd1 << 40;

    typedef struct packed {
        logic [CNT_W-1:0]   n;
        logic signed [31:0] start;
        logic signed [32:0] span;
        logic signed [31:0] base;
        logic signed [31:0] anchor;
        logic signed [32:0] dn;
        logic signed [32:0] dd;
    } t_job;

    typedef struct packed {
        logic             start;
        logic [NUM_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
        logic [6:0]       iters;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [NUM_W-1:0] quot;
    } t_div_rsp;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POINT,
        S_STEP,
        S_MUL,
        S_QUOT,
        S_EMIT
    } t_bstate;

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX) begin
            r = 32'sh7fffffff;
        end else if (v < S32_MIN) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/core/lipg_queue.sv
module lipg_queue #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_rd,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_cnt;
    logic             wr_ok, rd_ok;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_ok) begin
                r_wp <= (r_wp == PW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (rd_ok) begin
                r_rp <= (r_rp == PW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (wr_ok && !rd_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_ok && !wr_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

FILE: rtl/core/lipg_div.sv
module lipg_div
    import lipg_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [NUM_W-1:0] r_num, r_q;
    logic [DEN_W-1:0] r_rem, r_den;
    logic [6:0]       r_cnt;
    logic             r_busy;
    logic [DEN_W:0]   rem2;
    logic             ge;

    assign rem2 = {r_rem, r_num[NUM_W-1]};
    assign ge   = (rem2 >= {1'b0, r_den});

    assign o_rsp.done = r_busy && (r_cnt == '0);
    assign o_rsp.quot = r_q;

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_num <= i_req.dividend;
            r_den <= i_req.divisor;
            r_rem <= '0;
            r_q   <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_num <= r_num << 1;
            r_rem <= ge ? DEN_W'(rem2 - {1'b0, r_den}) : rem2[DEN_W-1:0];
            r_q   <= {r_q[NUM_W-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= i_req.iters;
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

FILE: rtl/core/lipg_front.sv
module lipg_front
    import lipg_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_cmd,
    input  logic [CNT_W-1:0]   i_point_count,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    input  logic               i_job_pop,
    output t_job               o_job,
    output logic               o_job_empty
);
    t_job               job;
    logic signed [32:0] x1, y1, x2, y2;
    logic               wr;

    assign x1 = 33'(i_first_x);
    assign y1 = 33'(i_first_y);
    assign x2 = 33'(i_second_x);
    assign y2 = 33'(i_second_y);

    always_comb begin
        job.n = (i_point_count > CNT_W'(MAX_POINTS)) ? CNT_W'(MAX_POINTS) : i_point_count;
        if (!i_cmd) begin
            job.start  = i_first_x;
            job.span   = x2 - x1;
            job.base   = i_first_y;
            job.anchor = i_first_x;
            job.dn     = y2 - y1;
            job.dd     = x2 - x1;
        end else begin
            job.start  = i_second_y;
            job.span   = y1 - y2;
            job.base   = i_first_x;
            job.anchor = i_first_y;
            job.dn     = x2 - x1;
            job.dd     = y2 - y1;
        end
    end

    // drop items with a zero count: they yield no results
    assign wr = i_push && (i_point_count != '0);

    lipg_queue #(
        .WIDTH($bits(t_job)),
        .DEPTH(2)
    ) u_jobq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_wr   (wr),
        .i_wdata(job),
        .i_rd   (i_job_pop),
        .o_rdata(o_job),
        .o_full (o_full),
        .o_empty(o_job_empty)
    );
endmodule

FILE: rtl/core/lipg_back.sv
module lipg_back
    import lipg_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_job               i_job,
    input  logic               i_job_empty,
    output logic               o_job_pop,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [CNT_W-1:0]   o_point_index,
    output logic signed [31:0] o_step_value,
    output logic signed [31:0] o_interpolated_value,
    output logic               o_divide_error,
    output logic               o_last_point
);
    t_bstate            r_state, n_state;
    t_job               r_job, n_job;
    logic [CNT_W-1:0]   r_idx, n_idx;
    logic signed [31:0] r_t, n_t, r_v, n_v;
    logic               r_err, n_err, r_neg, n_neg;
    logic [33:0]        r_ma, n_ma;
    logic [32:0]        r_mb, n_mb;
    logic [NUM_W-1:0]   r_acc, n_acc;
    logic [5:0]         r_cnt, n_cnt;
    logic               r_ov, n_ov;
    logic               load_out;
    t_div_req           div_req;
    t_div_rsp           div_rsp;

    logic signed [40:0] prod;
    logic [39:0]        prod_mag;
    logic signed [41:0] sq1, sq2;
    logic signed [31:0] t_new;
    logic signed [33:0] dt;
    logic [NUM_W-1:0]   qc;

    lipg_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (div_req),
        .o_rsp  (div_rsp)
    );

    assign prod     = r_job.span * $signed({1'b0, r_idx});
    assign prod_mag = prod[40] ? 40'(-prod) : prod[39:0];
    assign sq1      = r_neg ? -$signed({1'b0, div_rsp.quot[40:0]})
                            : $signed({1'b0, div_rsp.quot[40:0]});
    assign t_new    = sat32(42'(r_job.start) + sq1);
    assign dt       = 34'(t_new) - 34'(r_job.anchor);
    assign qc       = (div_rsp.quot > Q_CLAMP) ? Q_CLAMP : div_rsp.quot;
    assign sq2      = r_neg ? -$signed({1'b0, qc[40:0]}) : $signed({1'b0, qc[40:0]});

    always_comb begin
        n_state   = r_state;
        n_job     = r_job;
        n_idx     = r_idx;
        n_t       = r_t;
        n_v       = r_v;
        n_err     = r_err;
        n_neg     = r_neg;
        n_ma      = r_ma;
        n_mb      = r_mb;
        n_acc     = r_acc;
        n_cnt     = r_cnt;
        o_job_pop = 1'b0;
        load_out  = 1'b0;
        div_req   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_idx     = CNT_W'(1);
                    n_state   = S_POINT;
                end
            end
            S_POINT: begin
                div_req.start    = 1'b1;
                div_req.dividend = {prod_mag, 27'b0};
                div_req.divisor  = DEN_W'(r_job.n) + DEN_W'(1);
                div_req.iters    = 7'(STEP_ITERS);
                n_neg            = prod[40];
                n_state          = S_STEP;
            end
            S_STEP: begin
                if (div_rsp.done) begin
                    n_t = t_new;
                    if (r_job.dd == '0) begin
                        n_v     = '0;
                        n_err   = 1'b1;
                        n_state = S_EMIT;
                    end else begin
                        n_err   = 1'b0;
                        n_ma    = dt[33] ? 34'(-dt) : dt;
                        n_mb    = r_job.dn[32] ? 33'(-r_job.dn) : r_job.dn;
                        n_neg   = (dt[33] ^ r_job.dn[32]) ^ r_job.dd[32];
                        n_acc   = '0;
                        n_cnt   = 6'(MUL_STEPS);
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                if (r_cnt == '0) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = r_acc;
                    div_req.divisor  = r_job.dd[32] ? 33'(-r_job.dd) : r_job.dd;
                    div_req.iters    = 7'(SLOPE_ITERS);
                    n_state          = S_QUOT;
                end else begin
                    // shift-add, multiplier bits from the top down
                    n_acc = (r_acc << 1) + (r_mb[32] ? NUM_W'(r_ma) : '0);
                    n_mb  = r_mb << 1;
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_QUOT: begin
                if (div_rsp.done) begin
                    n_v     = sat32(42'(r_job.base) + sq2);
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_ov || i_pop) begin
                    load_out = 1'b1;
                    if (r_idx == r_job.n) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_POINT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ov = r_ov;
        if (load_out) begin
            n_ov = 1'b1;
        end else if (i_pop) begin
            n_ov = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_idx <= n_idx;
        r_t   <= n_t;
        r_v   <= n_v;
        r_err <= n_err;
        r_neg <= n_neg;
        r_ma  <= n_ma;
        r_mb  <= n_mb;
        r_acc <= n_acc;
        r_cnt <= n_cnt;
        if (load_out) begin
            o_point_index        <= r_idx;
            o_step_value         <= r_t;
            o_interpolated_value <= r_v;
            o_divide_error       <= r_err;
            o_last_point         <= (r_idx == r_job.n);
        end
    end

    assign o_empty = !r_ov;
endmodule

FILE: rtl/core/line_interpolation_point_generator.sv
// Two-point linear interpolation point generator.
// Input channel (push/full): one transfer carries two Q16.16 points, a count n
// and an axis select. Output channel (empty/pop): n results per input, one per
// interior point, with its index, the evenly spaced coordinate, the
// interpolated coordinate, a zero-divisor error flag and a last-point mark.
// A count of zero yields no results; counts above MAX_POINTS are clamped.
// When the back end is idle, it takes the job from the queue and then starts
// the first point. Points are computed one at a time, each through the
// shared radix-2 divider (40 then 67 iterations per point) and the 33-step
// serial multiplier between them; the next point starts once the last result
// has been loaded into the output register.
// A two-entry job queue lets new inputs transfer while a run is in progress.
// When the receiver stalls, the back end holds its finished result and waits;
// the queue then fills and full rises.
// Reset (synchronous, active low) empties the queue and the output register.
module line_interpolation_point_generator
    import lipg_pkg::*;
#(
    parameter int unsigned MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_cmd,
    input  logic [CNT_W-1:0]   i_point_count,
    input  logic signed [31:0] i_first_x,
    input  logic signed [31:0] i_first_y,
    input  logic signed [31:0] i_second_x,
    input  logic signed [31:0] i_second_y,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [CNT_W-1:0]   o_point_index,
    output logic signed [31:0] o_step_value,
    output logic signed [31:0] o_interpolated_value,
    output logic               o_divide_error,
    output logic               o_last_point
);
    t_job job;
    logic job_empty, job_pop;

    lipg_front #(
        .MAX_POINTS(MAX_POINTS)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (i_push),
        .o_full       (o_full),
        .i_cmd        (i_cmd),
        .i_point_count(i_point_count),
        .i_first_x    (i_first_x),
        .i_first_y    (i_first_y),
        .i_second_x   (i_second_x),
        .i_second_y   (i_second_y),
        .i_job_pop    (job_pop),
        .o_job        (job),
        .o_job_empty  (job_empty)
    );

    lipg_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_job               (job),
        .i_job_empty         (job_empty),
        .o_job_pop           (job_pop),
        .o_empty             (o_empty),
        .i_pop               (i_pop),
        .o_point_index       (o_point_index),
        .o_step_value        (o_step_value),
        .o_interpolated_value(o_interpolated_value),
        .o_divide_error      (o_divide_error),
        .o_last_point        (o_last_point)
    );
endmodule
